FILE: sv/lts_pkg.sv
// Shared types, constants and a helper function for the LRC timestamp parser.
package lts_pkg;

   // Default accumulator width for the minutes and seconds parts.
   localparam int ACC_WIDTH_DEF = 16;

   // Number of fraction digits that contribute to the millisecond value.
   localparam int FRACTION_DIGITS = 3;

   // Entries in the queue between the classifier and the executor.
   localparam int QUEUE_DEPTH = 4;

   // Milliseconds per minute and per second.
   localparam int MINUTE_MS = 60000;
   localparam int SECOND_MS = 1000;

   // Code units of interest.
   localparam logic [15:0] CHAR_ZERO  = 16'h0030;
   localparam logic [15:0] CHAR_NINE  = 16'h0039;
   localparam logic [15:0] CHAR_COLON = 16'h003A;
   localparam logic [15:0] CHAR_DOT   = 16'h002E;
   localparam logic [15:0] CHAR_COMMA = 16'h002C;

   // Part of the timestamp currently being collected.
   localparam logic [1:0] PART_MIN  = 2'd0;
   localparam logic [1:0] PART_SEC  = 2'd1;
   localparam logic [1:0] PART_FRAC = 2'd2;

   // Digit count saturates here.
   localparam logic [2:0] COUNT_SAT = 3'd4;

   // Class of one beat as decided by the front end.
   typedef enum logic [1:0] {
      CLS_NONE  = 2'd0,
      CLS_DIGIT = 2'd1,
      CLS_SEP   = 2'd2,
      CLS_OTHER = 2'd3
   } char_class_type;

   // One classified beat as it sits in the queue.
   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      logic           last;
   } queue_entry_type;

   // Weight of a fraction digit in milliseconds by its position.
   function automatic logic [9:0] frac_term(input logic [1:0] pos, input logic [3:0] d);
      logic [9:0] dw;
      dw = 10'(d);
      case (pos)
         2'd0:    return dw * 10'd100;
         2'd1:    return dw * 10'd10;
         default: return dw;
      endcase
   endfunction

endpackage

FILE: sv/lrc_timestamp_parser.sv
// Top level of the LRC timestamp parser: front end, beat queue and back end.
//
//  Channel  Direction  Payload                                    Handshake
//  req_     in         tdata: code_unit; tuser: no_char;          tvalid/tready
//                      tlast: ends_body
//  rsp_     out        tdata: time_ms; tuser: is_time             tvalid/tready
//
// One beat per cycle enters while the queue has room; the back end's single
// parse-state update per beat sets that rate. After its last beat leaves the queue, a
// result is registered in s1, s2 and out (state update, multiplications, sum, saturation).
// Reset is synchronous and clears the parse state, the queue and all valid flags.
// While a result waits on rsp_tready the back end holds, and the queue keeps
// taking input beats until it is full.
module lrc_timestamp_parser #(
   parameter int ACC_WIDTH = lts_pkg::ACC_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic [0:0]  req_tuser,   // [0] no_char
   input  logic        req_tlast,   // ends_body
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] time_ms
   output logic [0:0]  rsp_tuser    // [0] is_time
);

   // Classified beat passed from the front end into the queue.
   lts_pkg::queue_entry_type push_entry;
   // Oldest classified beat, offered to the back end.
   lts_pkg::queue_entry_type head_entry;
   logic push;
   logic pop;
   logic queue_full;
   logic queue_not_empty;

   // The front end decides what each code unit is, so the back end only sees
   // a digit value, a separator, an invalid character or an empty beat.
   lts_front u_front (
      .req_valid  (req_tvalid),
      .code_unit  (req_tdata),
      .no_char    (req_tuser[0]),
      .ends_body  (req_tlast),
      .queue_full (queue_full),
      .req_ready  (req_tready),
      .push       (push),
      .entry      (push_entry)
   );

   // The queue lets input continue while the back end is held by the output.
   lts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head_entry)
   );

   // The back end keeps the accumulators and turns a finished body into
   // milliseconds through a short pipeline ending in the output register.
   lts_back #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry       (head_entry),
      .entry_valid (queue_not_empty),
      .pop         (pop),
      .rsp_time    (rsp_tdata),
      .rsp_is_time (rsp_tuser[0]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready)
   );

endmodule

FILE: sv/lts_front.sv
// Front end: accepts input beats and classifies each code unit.
module lts_front (
   input  logic                     req_valid,
   input  logic [15:0]              code_unit,
   input  logic                     no_char,
   input  logic                     ends_body,
   input  logic                     queue_full,
   output logic                     req_ready,
   output logic                     push,
   output lts_pkg::queue_entry_type entry
);

   logic       is_digit;
   logic       is_sep;
   logic [15:0] offset;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   assign offset   = code_unit - lts_pkg::CHAR_ZERO;
   assign is_digit = (code_unit >= lts_pkg::CHAR_ZERO) && (code_unit <= lts_pkg::CHAR_NINE);
   assign is_sep   = (code_unit == lts_pkg::CHAR_COLON) || (code_unit == lts_pkg::CHAR_DOT) ||
                     (code_unit == lts_pkg::CHAR_COMMA);

   always_comb begin
      entry.digit = offset[3:0];
      entry.last  = ends_body;
      if (no_char) begin
         entry.cls = lts_pkg::CLS_NONE;
      end else if (is_digit) begin
         entry.cls = lts_pkg::CLS_DIGIT;
      end else if (is_sep) begin
         entry.cls = lts_pkg::CLS_SEP;
      end else begin
         entry.cls = lts_pkg::CLS_OTHER;
      end
   end

endmodule

FILE: sv/lts_queue.sv
// Short first-in first-out queue of classified beats.
module lts_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  lts_pkg::queue_entry_type push_data,
   input  logic                     pop,
   output logic                     full,
   output logic                     not_empty,
   output lts_pkg::queue_entry_type head
);

   localparam int AW = $clog2(lts_pkg::QUEUE_DEPTH);

   lts_pkg::queue_entry_type mem_ff [lts_pkg::QUEUE_DEPTH];
   logic [AW:0] wptr_ff, wptr_in;
   logic [AW:0] rptr_ff, rptr_in;

   assign not_empty = (wptr_ff != rptr_ff);
   assign full      = (wptr_ff[AW-1:0] == rptr_ff[AW-1:0]) && (wptr_ff[AW] != rptr_ff[AW]);
   assign head      = mem_ff[rptr_ff[AW-1:0]];

   assign wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
   assign rptr_in = pop  ? rptr_ff + 1'b1 : rptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff[AW-1:0]] <= push_data;
      end
   end

endmodule

FILE: sv/lts_back.sv
// Back end: runs the parse state and converts finished bodies to milliseconds.
module lts_back #(
   parameter int ACC_WIDTH = lts_pkg::ACC_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lts_pkg::queue_entry_type entry,
   input  logic                     entry_valid,
   output logic                     pop,
   output logic [31:0]              rsp_time,
   output logic                     rsp_is_time,
   output logic                     rsp_valid,
   input  logic                     rsp_ready
);

   localparam int SUM_W  = ACC_WIDTH + 17;
   localparam int WIDE_W = (SUM_W > 33) ? SUM_W : 33;
   localparam int PUSH_W = ACC_WIDTH + 4;
   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

   // Multiply by ten, add a digit, saturate.
   function automatic logic [ACC_WIDTH-1:0] acc_push(input logic [ACC_WIDTH-1:0] acc,
                                                     input logic [3:0] d);
      logic [PUSH_W-1:0] v;
      v = (PUSH_W'(acc) << 3) + (PUSH_W'(acc) << 1) + PUSH_W'(d);
      if (v > PUSH_W'(ACC_MAX)) begin
         return ACC_MAX;
      end
      return v[ACC_WIDTH-1:0];
   endfunction

   // Parse state.
   logic [ACC_WIDTH-1:0] min_ff, min_in, min_upd;
   logic [ACC_WIDTH-1:0] sec_ff, sec_in, sec_upd;
   logic [9:0]           frac_ff, frac_in, frac_upd;
   logic [1:0]           part_ff, part_in, part_upd;
   logic [2:0]           cnt_ff, cnt_in, cnt_upd;
   logic                 seen_ff, seen_in, seen_upd;
   logic                 bad_ff, bad_in, bad_upd;
   logic                 ok;

   // Conversion pipeline.
   logic                 adv;
   logic                 s1_v_ff, s1_v_in;
   logic                 s1_ok_ff;
   logic [ACC_WIDTH-1:0] s1_min_ff;
   logic [ACC_WIDTH-1:0] s1_sec_ff;
   logic [9:0]           s1_frac_ff;
   logic                 s2_v_ff;
   logic                 s2_ok_ff;
   logic [SUM_W-1:0]     s2_pmin_ff, s2_pmin_in;
   logic [SUM_W-1:0]     s2_psec_ff, s2_psec_in;
   logic [9:0]           s2_frac_ff;
   logic                 out_v_ff;
   logic                 out_ok_ff;
   logic [31:0]          out_time_ff, out_time_in;
   logic [SUM_W-1:0]     sum;
   logic [WIDE_W-1:0]    sum_wide;

   assign adv = !out_v_ff || rsp_ready;
   assign pop = adv && entry_valid;

   always_comb begin
      min_upd  = min_ff;
      sec_upd  = sec_ff;
      frac_upd = frac_ff;
      part_upd = part_ff;
      cnt_upd  = cnt_ff;
      seen_upd = seen_ff;
      bad_upd  = bad_ff;
      if (!bad_ff) begin
         unique case (entry.cls)
            lts_pkg::CLS_DIGIT: begin
               case (part_ff)
                  lts_pkg::PART_MIN: min_upd = acc_push(min_ff, entry.digit);
                  lts_pkg::PART_SEC: sec_upd = acc_push(sec_ff, entry.digit);
                  default: begin
                     if (cnt_ff < 3'(lts_pkg::FRACTION_DIGITS)) begin
                        frac_upd = frac_ff + lts_pkg::frac_term(cnt_ff[1:0], entry.digit);
                     end
                  end
               endcase
               if (cnt_ff < lts_pkg::COUNT_SAT) begin
                  cnt_upd = cnt_ff + 3'd1;
               end
               seen_upd = 1'b1;
            end
            lts_pkg::CLS_SEP: begin
               if (cnt_ff == 3'd0 || part_ff >= lts_pkg::PART_FRAC) begin
                  bad_upd = 1'b1;
               end else begin
                  part_upd = part_ff + 2'd1;
                  cnt_upd  = 3'd0;
               end
            end
            lts_pkg::CLS_OTHER: bad_upd = 1'b1;
            lts_pkg::CLS_NONE: ;
         endcase
      end
      ok = !bad_upd && seen_upd && (part_upd != lts_pkg::PART_MIN) && (cnt_upd != 3'd0);
   end

   always_comb begin
      min_in  = min_ff;
      sec_in  = sec_ff;
      frac_in = frac_ff;
      part_in = part_ff;
      cnt_in  = cnt_ff;
      seen_in = seen_ff;
      bad_in  = bad_ff;
      if (pop) begin
         if (entry.last) begin
            min_in  = '0;
            sec_in  = '0;
            frac_in = '0;
            part_in = lts_pkg::PART_MIN;
            cnt_in  = '0;
            seen_in = 1'b0;
            bad_in  = 1'b0;
         end else begin
            min_in  = min_upd;
            sec_in  = sec_upd;
            frac_in = frac_upd;
            part_in = part_upd;
            cnt_in  = cnt_upd;
            seen_in = seen_upd;
            bad_in  = bad_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= '0;
         sec_ff  <= '0;
         frac_ff <= '0;
         part_ff <= lts_pkg::PART_MIN;
         cnt_ff  <= '0;
         seen_ff <= 1'b0;
         bad_ff  <= 1'b0;
      end else begin
         min_ff  <= min_in;
         sec_ff  <= sec_in;
         frac_ff <= frac_in;
         part_ff <= part_in;
         cnt_ff  <= cnt_in;
         seen_ff <= seen_in;
         bad_ff  <= bad_in;
      end
   end

   assign s1_v_in    = pop && entry.last;
   assign s2_pmin_in = SUM_W'(s1_min_ff) * SUM_W'(lts_pkg::MINUTE_MS);
   assign s2_psec_in = SUM_W'(s1_sec_ff) * SUM_W'(lts_pkg::SECOND_MS);
   assign sum        = s2_pmin_ff + s2_psec_ff + SUM_W'(s2_frac_ff);
   assign sum_wide   = WIDE_W'(sum);
   assign out_time_in = (sum_wide[WIDE_W-1:32] != '0) ? 32'hFFFF_FFFF : sum_wide[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s1_v_ff;
         out_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ok_ff    <= ok;
         s1_min_ff   <= ok ? min_upd  : '0;
         s1_sec_ff   <= ok ? sec_upd  : '0;
         s1_frac_ff  <= ok ? frac_upd : '0;
         s2_ok_ff    <= s1_ok_ff;
         s2_pmin_ff  <= s2_pmin_in;
         s2_psec_ff  <= s2_psec_in;
         s2_frac_ff  <= s1_frac_ff;
         out_ok_ff   <= s2_ok_ff;
         out_time_ff <= out_time_in;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_time    = out_time_ff;
   assign rsp_is_time = out_ok_ff;

endmodule

FILE: sv/lts_checker.sv
// Port-level checks for the LRC timestamp parser, bound to the top level.
module lts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // A body that is not a time always reports zero milliseconds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("non-time result carries a nonzero time");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // No result is valid from an idle block as reset is released.
   assert property (@(posedge clock) $fell(reset) |-> !rsp_tvalid)
      else $error("result valid as reset is released");

   // Out of reset the queue is empty and takes a beat at once.
   assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready straight after reset");

   // A stalled result holds its beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind lrc_timestamp_parser lts_checker u_lts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: sim/testbench.sv
// Self-checking testbench for the LRC timestamp parser: directed and random bodies.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Accumulator width used both for the instance and for the predictor.
   localparam int ACC_W = lts_pkg::ACC_WIDTH_DEF;
   localparam longint unsigned ACC_MAX = (64'd1 << ACC_W) - 64'd1;

   // Beats of random stimulus after the directed table.
   localparam int RANDOM_BEATS = 950;
   // Cycles for which the receiver refuses results during the pressure test.
   localparam int HOLD_CYCLES = 200;
   // Cycles that the drain waits after every owed result has come out.
   localparam int LATENCY_CYCLES = 10;

   // One result as it appears on the rsp_ channel, time first, flag in bit 0.
   typedef struct packed {
      logic [31:0] time_ms;
      logic        is_time;
   } stamp_type;

   // One beat of a body as the sender builds it before driving it.
   typedef struct packed {
      logic        no_char;
      logic [15:0] unit;
   } beat_type;

   // One row of the directed table. Where typed is set, ms and ok give the
   // result that the row's final beat must produce; otherwise the predictor
   // decides.
   typedef struct packed {
      logic [15:0] unit;
      logic        no_char;
      logic        last;
      logic        typed;
      logic [31:0] ms;
      logic        ok;
   } row_type;

   localparam int DIRECTED_ROWS = 26;

   localparam row_type DIRECTED [DIRECTED_ROWS] = '{
      // An empty body: a single beat with no character ends it.
      '{16'h0000,                    1'b1, 1'b1, 1'b1, 32'd0,     1'b0},
      // "1:2", with a character-less beat inside that must be ignored.
      '{lts_pkg::CHAR_ZERO + 16'd1,  1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{16'hFFFF,                    1'b1, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_COLON,         1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_ZERO + 16'd2,  1'b0, 1'b1, 1'b1, 32'd62000, 1'b1},
      // A body made of one foreign character, the top code unit.
      '{16'hFFFF,                    1'b0, 1'b1, 1'b1, 32'd0,     1'b0},
      // A body that ends straight after a separator.
      '{lts_pkg::CHAR_ZERO + 16'd5,  1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_DOT,           1'b0, 1'b1, 1'b1, 32'd0,     1'b0},
      // A separator with no digit ahead of it in its part.
      '{lts_pkg::CHAR_COMMA,         1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_ZERO + 16'd1,  1'b0, 1'b1, 1'b1, 32'd0,     1'b0},
      // Digits only, no separator at all.
      '{lts_pkg::CHAR_ZERO + 16'd7,  1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_ZERO,          1'b0, 1'b1, 1'b1, 32'd0,     1'b0},
      // "0,5.0599": comma and dot as separators, fraction longer than kept.
      '{lts_pkg::CHAR_ZERO,          1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_COMMA,         1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_ZERO + 16'd5,  1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_DOT,           1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_ZERO,          1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_ZERO + 16'd5,  1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_ZERO + 16'd9,  1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_ZERO + 16'd9,  1'b0, 1'b1, 1'b0, 32'd0,     1'b0},
      // "1:2.3:": a separator while already in the fraction.
      '{lts_pkg::CHAR_ZERO + 16'd1,  1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_COLON,         1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_ZERO + 16'd2,  1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_DOT,           1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_ZERO + 16'd3,  1'b0, 1'b0, 1'b0, 32'd0,     1'b0},
      '{lts_pkg::CHAR_COLON,         1'b0, 1'b1, 1'b1, 32'd0,     1'b0}
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] code_unit
   logic [0:0]  req_tuser  = '0;   // [0] no_char
   logic        req_tlast  = 1'b0; // ends_body
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] time_ms
   logic [0:0]  rsp_tuser;         // [0] is_time

   // Results that the predictor has worked out and the block still owes.
   stamp_type pending_stamps[$];
   int        mismatch_count = 0;
   int        beats_sent = 0;

   // Shared between the sender and the receiver: calm switches idling off on
   // both sides, hold_request asks the receiver for one long hold-off.
   bit calm = 1'b0;
   bit hold_request = 1'b0;

   // The predictor's own copy of the parse state.
   logic [ACC_W-1:0] min_acc;
   logic [ACC_W-1:0] sec_acc;
   logic [9:0]       frac_ms;
   logic [1:0]       part_now;
   logic [2:0]       digit_count;
   bit               seen_digit;
   bit               body_bad;

   lrc_timestamp_parser #(
      .ACC_WIDTH(ACC_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop, far beyond the slowest correct run, even with every gap and
   // stall at its longest.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic clear_parse();
      min_acc     = '0;
      sec_acc     = '0;
      frac_ms     = '0;
      part_now    = lts_pkg::PART_MIN;
      digit_count = '0;
      seen_digit  = 1'b0;
      body_bad    = 1'b0;
   endtask

   // Decimal shift of a whole part, held at the top of the accumulator range.
   function automatic logic [ACC_W-1:0] push_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [3:0] d);
      longint unsigned v;
      v = 64'(acc) * 64'd10 + 64'(d);
      if (v > ACC_MAX)
         v = ACC_MAX;
      return v[ACC_W-1:0];
   endfunction

   // Advances the predicted parse by one accepted beat; on the final beat of
   // a body it hands back the result the block should produce.
   task automatic predict_beat(input logic [15:0] unit, input logic no_char,
                               input logic last, output bit has_stamp,
                               output stamp_type stamp);
      logic [3:0]      d;
      longint unsigned total;
      has_stamp = 1'b0;
      stamp = '0;
      if (!no_char && !body_bad) begin
         if (unit >= lts_pkg::CHAR_ZERO && unit <= lts_pkg::CHAR_NINE) begin
            d = 4'(unit - lts_pkg::CHAR_ZERO);
            case (part_now)
               lts_pkg::PART_MIN: begin
                  min_acc = push_digit(min_acc, d);
               end
               lts_pkg::PART_SEC: begin
                  sec_acc = push_digit(sec_acc, d);
               end
               default: begin
                  // Only the leading fraction digits carry weight.
                  if (digit_count < lts_pkg::FRACTION_DIGITS)
                     frac_ms += 10'(d) * (digit_count == 3'd0 ? 10'd100 :
                                          digit_count == 3'd1 ? 10'd10 : 10'd1);
               end
            endcase
            if (digit_count < lts_pkg::COUNT_SAT)
               digit_count++;
            seen_digit = 1'b1;
         end else if (unit == lts_pkg::CHAR_COLON || unit == lts_pkg::CHAR_DOT ||
                      unit == lts_pkg::CHAR_COMMA) begin
            if (digit_count == 3'd0 || part_now == lts_pkg::PART_FRAC) begin
               body_bad = 1'b1;
            end else begin
               part_now++;
               digit_count = '0;
            end
         end else begin
            body_bad = 1'b1;
         end
      end
      if (last) begin
         has_stamp = 1'b1;
         if (!body_bad && seen_digit && part_now != lts_pkg::PART_MIN &&
             digit_count != 3'd0) begin
            total = 64'(min_acc) * 64'(lts_pkg::MINUTE_MS)
                    + 64'(sec_acc) * 64'(lts_pkg::SECOND_MS) + 64'(frac_ms);
            stamp.time_ms = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
            stamp.is_time = 1'b1;
         end
         clear_parse();
      end
   endtask

   // Offers one beat and waits for its handshake. The predictor runs on the
   // accepting edge, so its state always follows what the block has taken.
   // A typed expectation, where given, replaces the predicted result.
   task automatic send_beat(input logic [15:0] unit, input logic no_char,
                            input logic last, input bit typed,
                            input stamp_type typed_stamp);
      bit        has_stamp;
      stamp_type stamp;
      req_tvalid <= 1'b1;
      req_tdata  <= unit;
      req_tuser  <= no_char;
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      beats_sent++;
      predict_beat(unit, no_char, last, has_stamp, stamp);
      if (has_stamp)
         pending_stamps.push_back(typed ? typed_stamp : stamp);
      // Each following cycle is idle with the same chance, unless the calm
      // stretch is running.
      while (!calm && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic beat_type digit_beat();
      return '{no_char: 1'b0, unit: lts_pkg::CHAR_ZERO + 16'($urandom_range(0, 9))};
   endfunction

   function automatic beat_type separator_beat();
      case ($urandom_range(0, 2))
         0:       return '{no_char: 1'b0, unit: lts_pkg::CHAR_COLON};
         1:       return '{no_char: 1'b0, unit: lts_pkg::CHAR_DOT};
         default: return '{no_char: 1'b0, unit: lts_pkg::CHAR_COMMA};
      endcase
   endfunction

   // Anything at all: digits, separators, arbitrary code units or empty beats.
   function automatic beat_type noise_beat();
      case ($urandom_range(0, 3))
         0:       return digit_beat();
         1:       return separator_beat();
         2:       return '{no_char: 1'b0, unit: 16'($urandom_range(0, 65535))};
         default: return '{no_char: 1'b1, unit: 16'($urandom_range(0, 65535))};
      endcase
   endfunction

   // Mostly well-formed timestamps with random content; now and then an
   // oversized whole part to drive the accumulators into saturation, a stray
   // beat somewhere inside, or a body of pure noise.
   task automatic send_random_body();
      beat_type  body[$];
      stamp_type no_stamp;
      int        n;
      no_stamp = '0;
      if ($urandom_range(0, 99) < 80) begin
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
         repeat (n) body.push_back(digit_beat());
         body.push_back(separator_beat());
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 2);
         repeat (n) body.push_back(digit_beat());
         if ($urandom_range(0, 99) < 70) begin
            body.push_back(separator_beat());
            repeat ($urandom_range(0, 5)) body.push_back(digit_beat());
         end
         if ($urandom_range(0, 99) < 15)
            body.insert($urandom_range(0, body.size()), noise_beat());
         if ($urandom_range(0, 99) < 20)
            body.insert($urandom_range(0, body.size()),
                        '{no_char: 1'b1, unit: 16'($urandom_range(0, 65535))});
      end else begin
         repeat ($urandom_range(1, 6)) body.push_back(noise_beat());
      end
      // Sometimes the body is closed by an empty beat rather than a character.
      if ($urandom_range(0, 99) < 20)
         body.push_back('{no_char: 1'b1, unit: 16'($urandom_range(0, 65535))});
      foreach (body[i])
         send_beat(body[i].unit, body[i].no_char, i == body.size() - 1, 1'b0, no_stamp);
   endtask

   // Lets every owed result come out, then a few cycles more.
   task automatic drain_results();
      while (pending_stamps.size() != 0)
         @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   // Receiver: refuses results in about a third of the cycles, never during
   // the calm stretch, and once for a long hold-off so that the block backs
   // up into its queue and stops taking beats.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 31);
      end
   end

   // Result checker: each accepted result is matched against the oldest one
   // owed, field by field.
   always @(posedge clock) begin
      stamp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_stamps.size() == 0) begin
            report_mismatch("result with none owed, time_ms", rsp_tdata, 32'd0);
         end else begin
            want = pending_stamps.pop_front();
            if (rsp_tdata !== want.time_ms)
               report_mismatch("time_ms", rsp_tdata, want.time_ms);
            if (rsp_tuser[0] !== want.is_time)
               report_mismatch("is_time", 32'(rsp_tuser[0]), 32'(want.is_time));
         end
      end
   end

   // Sender: reset, the directed table, then random bodies with the pressure
   // tests placed at fixed points along the way.
   initial begin
      int body_no;
      clear_parse();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i])
         send_beat(DIRECTED[i].unit, DIRECTED[i].no_char, DIRECTED[i].last,
                   DIRECTED[i].typed, {DIRECTED[i].ms, DIRECTED[i].ok});
      req_tvalid <= 1'b0;
      drain_results();

      body_no = 0;
      while (beats_sent < DIRECTED_ROWS + RANDOM_BEATS) begin
         // The receiver goes quiet while bodies keep coming.
         if (body_no == 30)
            hold_request = 1'b1;
         // The sender stops until every owed result is out.
         if (body_no == 60) begin
            req_tvalid <= 1'b0;
            drain_results();
         end
         calm = (body_no >= 80 && body_no < 110);
         send_random_body();
         body_no++;
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;
      drain_results();

      if (mismatch_count == 0 && pending_stamps.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
